// File: rtl/ptc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants for the barometer compensation core.
// ----------------------------------------------------------------------------
package ptc_pkg;

  // register indexes
  localparam logic [1:0] REG_TEMP_CALIB  = 2'd0;
  localparam logic [1:0] REG_PRESS_LOW   = 2'd1;
  localparam logic [1:0] REG_PRESS_HIGH  = 2'd2;
  localparam logic [1:0] REG_PRESS_LAST  = 2'd3;

  localparam logic signed [31:0] TF_MIN = -32'sd204800;
  localparam logic signed [31:0] TF_MAX = 32'sd435200;
  localparam logic [31:0] PRESS_MIN = 32'd7680000;
  localparam logic [31:0] PRESS_MAX = 32'd28160000;

  // calibration set
  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0]        p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } calib_t;

  // beat passed from front to back
  typedef struct packed {
    logic signed [31:0] tf;
    logic signed [63:0] num;
    logic signed [63:0] den;
    logic [19:0]        adc_p;
  } div_job_t;

endpackage

`default_nettype wire

// File: rtl/ptc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_front
// Temperature and pressure pre-division terms, pipelined, one sample a cycle.
// ----------------------------------------------------------------------------
module ptc_front import ptc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire calib_t      cal,
  input  wire logic        in_valid,
  input  wire logic [19:0] raw_temperature,
  input  wire logic [19:0] raw_pressure,
  output logic             out_valid,
  output div_job_t         out_job
);

  localparam int STAGES = 6;
  logic [STAGES-1:0] vld;

  // stage 1: temperature products
  logic signed [31:0] s1_d1, s1_d2;
  logic signed [31:0] s1_pa, s1_pb;
  logic [19:0] s1_adcp;
  always_comb begin
    s1_d1 = $signed({15'd0, raw_temperature[19:3]}) - $signed({15'd0, cal.t1, 1'b0});
    s1_d2 = $signed({16'd0, raw_temperature[19:4]}) - $signed({16'd0, cal.t1});
  end
  logic signed [31:0] r1_a, r1_bsq;
  logic [19:0] r1_adcp;
  always_ff @(posedge clk) begin
    r1_a    <= 32'(s1_d1 * 32'(cal.t2));
    r1_bsq  <= 32'(s1_d2 * s1_d2);
    r1_adcp <= raw_pressure;
  end
  assign s1_pa = r1_a >>> 11;
  assign s1_pb = r1_bsq >>> 12;
  assign s1_adcp = r1_adcp;

  // stage 2: t3 term
  logic signed [31:0] r2_a, r2_b;
  logic [19:0] r2_adcp;
  always_ff @(posedge clk) begin
    r2_a    <= s1_pa;
    r2_b    <= 32'(s1_pb * 32'(cal.t3));
    r2_adcp <= s1_adcp;
  end

  // stage 3: t_fine and v1 powers
  logic signed [31:0] tf3;
  assign tf3 = r2_a + (r2_b >>> 14);
  logic signed [63:0] v1_3;
  assign v1_3 = 64'(tf3) - 64'sd128000;
  logic signed [31:0] r3_tf;
  logic signed [63:0] r3_v1, r3_sq;
  logic [19:0] r3_adcp;
  always_ff @(posedge clk) begin
    r3_tf   <= tf3;
    r3_v1   <= v1_3;
    r3_sq   <= v1_3 * v1_3;
    r3_adcp <= r2_adcp;
  end

  // stage 4: coefficient products
  logic signed [31:0] r4_tf;
  logic signed [63:0] r4_sq6, r4_v5, r4_sq3, r4_v2;
  logic [19:0] r4_adcp;
  always_ff @(posedge clk) begin
    r4_tf   <= r3_tf;
    r4_sq6  <= r3_sq * 64'(cal.p6);
    r4_v5   <= r3_v1 * 64'(cal.p5);
    r4_sq3  <= r3_sq * 64'(cal.p3);
    r4_v2   <= r3_v1 * 64'(cal.p2);
    r4_adcp <= r3_adcp;
  end

  // stage 5: var2 and denominator product
  logic signed [63:0] v2_5, v1_5;
  assign v2_5 = r4_sq6 + (r4_v5 <<< 17) + (64'(cal.p4) <<< 35);
  assign v1_5 = (r4_sq3 >>> 8) + (r4_v2 <<< 12);
  logic signed [31:0] r5_tf;
  logic signed [63:0] r5_v2, r5_den;
  logic [19:0] r5_adcp;
  always_ff @(posedge clk) begin
    r5_tf   <= r4_tf;
    r5_v2   <= v2_5;
    r5_den  <= ((64'sd1 <<< 47) + v1_5) * $signed({48'd0, cal.p1});
    r5_adcp <= r4_adcp;
  end

  // stage 6: numerator
  logic signed [63:0] pn;
  assign pn = $signed(64'd1048576 - {44'd0, r5_adcp});
  always_ff @(posedge clk) begin
    out_job.tf    <= r5_tf;
    out_job.den   <= r5_den >>> 33;
    out_job.num   <= ((pn <<< 31) - r5_v2) * 64'sd3125;
    out_job.adc_p <= r5_adcp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end
  assign out_valid = vld[STAGES-1];

endmodule

`default_nettype wire

// File: rtl/ptc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_queue
// One-entry register queue between front and back halves.
// ----------------------------------------------------------------------------
module ptc_queue import ptc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     wr_valid,
  input  wire div_job_t wr_job,
  output logic          rd_valid,
  output div_job_t      rd_job
);

  // back half never stalls, so one slot drains each cycle
  div_job_t slot;
  logic     full;
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= wr_valid;
    end
  end
  always_ff @(posedge clk) begin
    slot <= wr_job;
  end
  assign rd_valid = full;
  assign rd_job   = slot;

endmodule

`default_nettype wire

// File: rtl/ptc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_back
// Pipelined radix-2 signed divider and pressure finishing terms.
// ----------------------------------------------------------------------------
module ptc_back import ptc_pkg::*; (
  input  wire calib_t      cal,
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire div_job_t    in_job,
  output logic             done,
  output logic [23:0]      fine_temperature,
  output logic [31:0]      pressure_q24_8,
  output logic             zero_divisor,
  output logic             in_range
);

  localparam int N = 64;

  // stage registers, index i holds the state after i quotient bits
  logic [N:1]         v;
  logic [N-1:0]       rem  [1:N];
  logic [N-1:0]       quo  [1:N];
  logic [N-1:0]       dvs  [1:N];
  logic [N:1]         neg;
  logic [N:1]         zd;
  logic signed [31:0] tf   [1:N];

  // one quotient bit per stage
  for (genvar i = 0; i < N; i++) begin : g_div
    logic               vi, ni, zi;
    logic [N-1:0]       ri, qi, di;
    logic signed [31:0] ti;
    logic [N:0]         trial;
    logic [N-1:0]       sh;
    if (i == 0) begin : g_head
      // magnitudes and sign of the incoming job
      assign vi = in_valid;
      assign ri = '0;
      assign qi = in_job.num[63] ? 64'(-in_job.num) : in_job.num;
      assign di = in_job.den[63] ? 64'(-in_job.den) : in_job.den;
      assign ni = in_job.num[63] ^ in_job.den[63];
      assign zi = (in_job.den == 64'sd0);
      assign ti = in_job.tf;
    end else begin : g_body
      assign vi = v[i];
      assign ri = rem[i];
      assign qi = quo[i];
      assign di = dvs[i];
      assign ni = neg[i];
      assign zi = zd[i];
      assign ti = tf[i];
    end
    assign sh    = {ri[N-2:0], qi[N-1]};
    assign trial = {1'b0, sh} - {1'b0, di};
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else begin
        v[i+1] <= vi;
      end
    end
    always_ff @(posedge clk) begin
      if (ri[N-1] || !trial[N]) begin
        rem[i+1] <= trial[N-1:0];
        quo[i+1] <= {qi[N-2:0], 1'b1};
      end else begin
        rem[i+1] <= sh;
        quo[i+1] <= {qi[N-2:0], 1'b0};
      end
      dvs[i+1] <= di;
      neg[i+1] <= ni;
      zd[i+1]  <= zi;
      tf[i+1]  <= ti;
    end
  end

  // finishing stage a: signed quotient and products
  logic signed [63:0] q;
  assign q = neg[N] ? 64'(-quo[N]) : quo[N];
  logic signed [63:0] qs;
  assign qs = q >>> 13;
  logic               fa_v, fa_zd;
  logic signed [31:0] fa_tf;
  logic signed [63:0] fa_p, fa_p9q, fa_qs, fa_b;
  always_ff @(posedge clk) begin
    if (rst) begin
      fa_v <= 1'b0;
    end else begin
      fa_v <= v[N];
    end
  end
  always_ff @(posedge clk) begin
    fa_zd  <= zd[N];
    fa_tf  <= tf[N];
    fa_p   <= q;
    fa_p9q <= 64'(cal.p9) * qs;
    fa_qs  <= qs;
    fa_b   <= 64'(cal.p8) * q;
  end

  // finishing stage b: partial products of the 32-bit halves of the quadratic term
  logic               fb_v, fb_zd;
  logic signed [31:0] fb_tf;
  logic signed [63:0] fb_p, fb_b;
  logic [63:0]        fb_ll;
  logic [31:0]        fb_lh, fb_hl;
  always_ff @(posedge clk) begin
    if (rst) begin
      fb_v <= 1'b0;
    end else begin
      fb_v <= fa_v;
    end
  end
  always_ff @(posedge clk) begin
    fb_zd <= fa_zd;
    fb_tf <= fa_tf;
    fb_p  <= fa_p;
    fb_ll <= 64'(fa_p9q[31:0]) * 64'(fa_qs[31:0]);
    fb_lh <= fa_p9q[31:0] * fa_qs[63:32];
    fb_hl <= fa_p9q[63:32] * fa_qs[31:0];
    fb_b  <= fa_b >>> 19;
  end

  // finishing stage c: low 64 bits of the quadratic term
  logic               fc_v, fc_zd;
  logic signed [31:0] fc_tf;
  logic signed [63:0] fc_p, fc_a, fc_b;
  always_ff @(posedge clk) begin
    if (rst) begin
      fc_v <= 1'b0;
    end else begin
      fc_v <= fb_v;
    end
  end
  always_ff @(posedge clk) begin
    fc_zd <= fb_zd;
    fc_tf <= fb_tf;
    fc_p  <= fb_p;
    fc_a  <= $signed(fb_ll + {fb_lh + fb_hl, 32'd0});
    fc_b  <= fb_b;
  end

  // output stage
  logic signed [63:0] pf;
  logic [31:0] pr;
  logic ok;
  assign pf = ((fc_p + (fc_a >>> 25) + fc_b) >>> 8) + (64'(cal.p7) <<< 4);
  assign pr = fc_zd ? 32'd0 : pf[31:0];
  assign ok = !fc_zd && fc_tf >= TF_MIN && fc_tf <= TF_MAX &&
              pr >= PRESS_MIN && pr <= PRESS_MAX;
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fc_v;
    end
  end
  always_ff @(posedge clk) begin
    fine_temperature <= fc_tf[23:0];
    pressure_q24_8   <= pr;
    zero_divisor     <= fc_zd;
    in_range         <= ok;
  end

endmodule

`default_nettype wire

// File: rtl/pressure_temperature_compensation_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_core
// Barometer compensation: fine temperature and Q24.8 pressure per sample.
// Path from start to done: 6 front stages, 1 queue slot,
// 64 divider stages (one quotient bit each), 4 finishing stages.
// Throughput one sample per cycle; busy is always low.
// Synchronous reset clears pipeline valids and calibration registers.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation_core import ptc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [19:0] raw_temperature,
  input  wire logic [19:0] raw_pressure,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  output logic             done,
  output logic [23:0]      fine_temperature,
  output logic [31:0]      pressure_q24_8,
  output logic             zero_divisor,
  output logic             in_range
);

  // calibration registers
  logic [47:0] temp_calib;
  logic [63:0] press_calib_low, press_calib_high;
  logic [15:0] press_calib_last;
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib       <= '0;
      press_calib_low  <= '0;
      press_calib_high <= '0;
      press_calib_last <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEMP_CALIB: temp_calib       <= cfg_data[47:0];
        REG_PRESS_LOW:  press_calib_low  <= cfg_data;
        REG_PRESS_HIGH: press_calib_high <= cfg_data;
        REG_PRESS_LAST: press_calib_last <= cfg_data[15:0];
        default:        temp_calib       <= temp_calib;
      endcase
    end
  end

  calib_t cal;
  always_comb begin
    cal.t1 = temp_calib[15:0];
    cal.t2 = temp_calib[31:16];
    cal.t3 = temp_calib[47:32];
    cal.p1 = press_calib_low[15:0];
    cal.p2 = press_calib_low[31:16];
    cal.p3 = press_calib_low[47:32];
    cal.p4 = press_calib_low[63:48];
    cal.p5 = press_calib_high[15:0];
    cal.p6 = press_calib_high[31:16];
    cal.p7 = press_calib_high[47:32];
    cal.p8 = press_calib_high[63:48];
    cal.p9 = press_calib_last;
  end

  assign busy = 1'b0;

  logic     f_v, q_v;
  div_job_t f_job, q_job;

  ptc_front u_front (
    .clk(clk), .rst(rst), .cal(cal), .in_valid(start),
    .raw_temperature(raw_temperature), .raw_pressure(raw_pressure),
    .out_valid(f_v), .out_job(f_job)
  );

  ptc_queue u_queue (
    .clk(clk), .rst(rst), .wr_valid(f_v), .wr_job(f_job),
    .rd_valid(q_v), .rd_job(q_job)
  );

  ptc_back u_back (
    .cal(cal), .clk(clk), .rst(rst), .in_valid(q_v), .in_job(q_job),
    .done(done), .fine_temperature(fine_temperature),
    .pressure_q24_8(pressure_q24_8), .zero_divisor(zero_divisor),
    .in_range(in_range)
  );

endmodule

`default_nettype wire

// File: test/pressure_temperature_compensation_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_core_tb
// Self-checking bench for the barometer compensation core. A directed table
// runs at reset and fixed calibration sets, then random calibration phases
// send realistic, extreme and noise readings. All but the at-reset rows are
// predicted with 32/64-bit wrapping integer math; all are checked field by field.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation_core_tb;
  import ptc_pkg::*;

  typedef struct packed {
    logic [23:0] fine;
    logic [31:0] press;
    logic        zdiv;
    logic        ok;
  } reading_t;

  typedef struct {
    int          cal_set;
    logic [19:0] raw_t;
    logic [19:0] raw_p;
    bit          typed;
    reading_t    want;
  } vector_t;

  localparam reading_t AT_RESET = '{fine: 24'd0, press: 32'd0, zdiv: 1'b1, ok: 1'b0};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [19:0] raw_temperature = '0;
  logic [19:0] raw_pressure = '0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_TEMP_CALIB;
  logic [63:0] cfg_data = '0;
  logic        done;
  logic [23:0] fine_temperature;
  logic [31:0] pressure_q24_8;
  logic        zero_divisor;
  logic        in_range;

  // calibration copy kept in step with the writes
  logic [47:0] temp_cal = '0;
  logic [63:0] press_lo = '0;
  logic [63:0] press_hi = '0;
  logic [15:0] press_p9 = '0;

  reading_t pending_readings[$];
  bit       cur_typed = 1'b0;
  reading_t cur_want = '0;
  int       accepted = 0;
  int       checked = 0;
  int       errors = 0;
  int       in_range_seen = 0;
  int       zdiv_seen = 0;

  pressure_temperature_compensation_core DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // compensation predictor: 32-bit temperature, 64-bit pressure
  function automatic reading_t compensate(input logic [19:0] rt, input logic [19:0] rp);
    longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    longint d, a, b, tf, v1, v2, p, num;
    reading_t r;
    t1 = longint'(temp_cal[15:0]);
    t2 = longint'($signed(temp_cal[31:16]));
    t3 = longint'($signed(temp_cal[47:32]));
    p1 = longint'(press_lo[15:0]);
    p2 = longint'($signed(press_lo[31:16]));
    p3 = longint'($signed(press_lo[47:32]));
    p4 = longint'($signed(press_lo[63:48]));
    p5 = longint'($signed(press_hi[15:0]));
    p6 = longint'($signed(press_hi[31:16]));
    p7 = longint'($signed(press_hi[47:32]));
    p8 = longint'($signed(press_hi[63:48]));
    p9 = longint'($signed(press_p9));
    d = longint'(rt >> 3) - (t1 << 1);
    a = longint'(int'(d * t2)) >>> 11;
    d = longint'(rt >> 4) - t1;
    b = longint'(int'(d * d)) >>> 12;
    b = longint'(int'(b * t3)) >>> 14;
    tf = longint'(int'(a + b));
    v1 = tf - 64'sd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) << 12);
    v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
    r.fine = tf[23:0];
    r.zdiv = (v1 == 0);
    if (r.zdiv) begin
      r.press = '0;
    end else begin
      p = 64'sd1048576 - longint'(rp);
      num = ((p << 31) - v2) * 64'sd3125;
      // quotient of most negative by -1 wraps to itself
      p = (v1 == -64'sd1) ? -num : num / v1;
      a = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
      b = (p8 * p) >>> 19;
      p = ((p + a + b) >>> 8) + (p7 << 4);
      r.press = p[31:0];
    end
    r.ok = !r.zdiv && tf >= longint'(TF_MIN) && tf <= longint'(TF_MAX) &&
           r.press >= PRESS_MIN && r.press <= PRESS_MAX;
    return r;
  endfunction

  // accept beats and check results
  always @(posedge clk) begin
    reading_t got, want;
    if (!rst) begin
      if (start && !busy) begin
        pending_readings.push_back(cur_typed ? cur_want :
                                   compensate(raw_temperature, raw_pressure));
        accepted++;
      end
      if (done) begin
        got = '{fine: fine_temperature, press: pressure_q24_8, zdiv: zero_divisor,
                ok: in_range};
        if (pending_readings.size() == 0) begin
          $display("%0t: unexpected beat, actual %h", $time, got);
          errors++;
        end else begin
          want = pending_readings.pop_front();
          checked++;
          if (got.zdiv) zdiv_seen++;
          if (got.ok) in_range_seen++;
          if (got.fine !== want.fine) begin
            $display("%0t: fine_temperature expected %h actual %h", $time, want.fine, got.fine);
            errors++;
          end
          if (got.press !== want.press) begin
            $display("%0t: pressure_q24_8 expected %h actual %h", $time, want.press,
                     got.press);
            errors++;
          end
          if (got.zdiv !== want.zdiv) begin
            $display("%0t: zero_divisor expected %b actual %b", $time, want.zdiv, got.zdiv);
            errors++;
          end
          if (got.ok !== want.ok) begin
            $display("%0t: in_range expected %b actual %b", $time, want.ok, got.ok);
            errors++;
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_TEMP_CALIB: temp_cal = val[47:0];
      REG_PRESS_LOW:  press_lo = val;
      REG_PRESS_HIGH: press_hi = val;
      REG_PRESS_LAST: press_p9 = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_calibration(input logic [255:0] cal);
    write_reg(REG_PRESS_LAST, cal[255:192]);
    write_reg(REG_TEMP_CALIB, cal[191:128]);
    write_reg(REG_PRESS_HIGH, cal[127:64]);
    write_reg(REG_PRESS_LOW, cal[63:0]);
  endtask

  task automatic drain();
    while (pending_readings.size() != 0) @(negedge clk);
  endtask

  // one beat, followed by a sender gap
  task automatic send_reading(input logic [19:0] rt, input logic [19:0] rp, input bit typed,
                              input reading_t want, input int gap);
    int n;
    n = accepted;
    start <= 1'b1;
    raw_temperature <= rt;
    raw_pressure <= rp;
    cur_typed = typed;
    cur_want = want;
    while (accepted == n) @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic logic [15:0] edge_word();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'h7fff;
      2: return 16'h8000;
      3: return 16'hffff;
      default: return 16'h0001;
    endcase
  endfunction

  function automatic logic [19:0] edge_raw();
    case ($urandom_range(0, 3))
      0: return 20'h00000;
      1: return 20'hfffff;
      2: return 20'h80000;
      default: return 20'h7ffff;
    endcase
  endfunction

  // calibration sets as {p9, t3 t2 t1, p8 p7 p6 p5, p4 p3 p2 p1}
  localparam logic [63:0] TYP_T  = {16'd0, 16'hfc18, 16'd26435, 16'd27504};
  localparam logic [63:0] TYP_PH = {16'hc6f8, 16'd15500, 16'hfff9, 16'd140};
  localparam logic [63:0] TYP_PL = {16'd2855, 16'd3024, 16'hd643, 16'd36477};
  logic [255:0] cal_sets [5];

  vector_t dir_table [] = '{
    '{0, 20'h00000, 20'h00000, 1'b1, AT_RESET},
    '{0, 20'hfffff, 20'hfffff, 1'b1, AT_RESET},
    '{0, 20'h80000, 20'h7ffff, 1'b1, AT_RESET},
    '{1, 20'd519888, 20'd415148, 1'b0, '0},
    '{1, 20'd519888, 20'd300000, 1'b0, '0},
    '{1, 20'd450000, 20'd600000, 1'b0, '0},
    '{1, 20'h00000, 20'h00000, 1'b0, '0},
    '{1, 20'hfffff, 20'hfffff, 1'b0, '0},
    '{1, 20'h00000, 20'hfffff, 1'b0, '0},
    '{1, 20'hfffff, 20'h00000, 1'b0, '0},
    '{1, 20'd640000, 20'd180000, 1'b0, '0},
    '{2, 20'd519888, 20'd415148, 1'b0, '0},
    '{2, 20'hfffff, 20'h00000, 1'b0, '0},
    '{3, 20'h00000, 20'h00000, 1'b0, '0},
    '{3, 20'hfffff, 20'hfffff, 1'b0, '0},
    '{3, 20'd519888, 20'd415148, 1'b0, '0},
    '{4, 20'h00000, 20'hfffff, 1'b0, '0},
    '{4, 20'hfffff, 20'h00000, 1'b0, '0},
    '{4, 20'h80000, 20'h80000, 1'b0, '0}
  };

  initial begin
    int prev_set;
    int mode, gap_max;
    logic [255:0] cal;
    logic [19:0] rt, rp;
    cal_sets[0] = '0;
    cal_sets[1] = {64'd6000, TYP_T, TYP_PH, TYP_PL};
    // typical but P1 zero, so the divisor vanishes with a live temperature
    cal_sets[2] = {64'd6000, TYP_T, TYP_PH, TYP_PL & ~64'hffff};
    // every word at its top; T2 large can push t_fine outside the TF_MIN..TF_MAX window
    cal_sets[3] = {64'h7fff, {16'h0000, 16'h7fff, 16'h7fff, 16'hffff}, 64'h7fff7fff7fff7fff,
                   64'h7fff7fff7fff_ffff};
    cal_sets[4] = {64'h8000, {16'h0000, 16'h8000, 16'h8000, 16'h0000}, 64'h8000800080008000,
                   64'h800080008000_0001};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    prev_set = 0;
    foreach (dir_table[i]) begin
      if (dir_table[i].cal_set != prev_set) begin
        start <= 1'b0;
        @(negedge clk);
        drain();
        load_calibration(cal_sets[dir_table[i].cal_set]);
        prev_set = dir_table[i].cal_set;
      end
      send_reading(dir_table[i].raw_t, dir_table[i].raw_p, dir_table[i].typed,
                   dir_table[i].want, $urandom_range(0, 3));
    end

    // random phases, each with its own calibration
    for (int ph = 0; ph < 9; ph++) begin
      start <= 1'b0;
      @(negedge clk);
      drain();
      mode = (ph % 3 == 2) ? $urandom_range(1, 2) : 0;
      cal = cal_sets[1];
      for (int w = 0; w < 13; w++) begin
        if (mode == 0)
          cal[w*16 +: 16] = cal[w*16 +: 16] + 16'($urandom_range(0, 64)) - 16'd32;
        else if (mode == 1)
          cal[w*16 +: 16] = 16'($urandom);
        else
          cal[w*16 +: 16] = edge_word();
      end
      if (ph == 8) cal = {64'h7fff, 64'hffffffffffff, 64'hffffffffffffffff,
                          64'hffffffffffffffff};
      load_calibration(cal);
      gap_max = (ph % 4 == 1) ? 0 : 17;
      for (int k = 0; k < 150; k++) begin
        case ($urandom_range(0, 9))
          0, 1: begin rt = 20'($urandom); rp = 20'($urandom); end
          2: begin rt = edge_raw(); rp = edge_raw(); end
          default: begin
            rt = 20'($urandom_range(420000, 620000));
            rp = 20'($urandom_range(150000, 700000));
          end
        endcase
        send_reading(rt, rp, 1'b0, '0, ($urandom_range(0, 3) == 0) ?
                     $urandom_range(0, gap_max) : 0);
      end
    end

    start <= 1'b0;
    @(negedge clk);
    drain();
    repeat (80) @(negedge clk);
    $display("checked %0d readings over 14 calibration sets", checked);
    $display("in range %0d, zero divisor %0d", in_range_seen, zdiv_seen);
    if (errors == 0 && pending_readings.size() == 0) begin
      $display("PASS pressure_temperature_compensation_core");
    end else begin
      $display("FAIL pressure_temperature_compensation_core");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("FAIL pressure_temperature_compensation_core");
    $finish;
  end

endmodule

// File: filelist.f
rtl/ptc_pkg.sv
rtl/ptc_front.sv
rtl/ptc_queue.sv
rtl/ptc_back.sv
rtl/pressure_temperature_compensation_core.sv
test/pressure_temperature_compensation_core_tb.sv
